[rtl/core/texture_region_masked_blend_write_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the texture region blend writer
// Each macro expects clk and arst_n to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef TEXTURE_REGION_MASKED_BLEND_WRITE_ASSERT_SVH
`define TEXTURE_REGION_MASKED_BLEND_WRITE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRMBW_ASSERT_SAME(lbl, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TRMBW_ASSERT_NEXT(lbl, cond, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("%m: next-cycle check failed");

`endif

[rtl/core/trmbw_pkg.sv]
// ---------------------------------------------------------------------------
// trmbw_pkg
// Shared constants, codes and control types of the texture region blend writer.
// ---------------------------------------------------------------------------
package trmbw_pkg;

	localparam int MAX_SIDE    = 64;
	localparam int SIDE_W      = $clog2(MAX_SIDE);
	localparam int DIM_W       = SIDE_W + 1;
	localparam int DEPTH       = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CHAN_W      = 8;
	localparam int NUM_CHAN    = 3;
	localparam int PIX_W       = CHAN_W * NUM_CHAN;
	localparam int WEIGHT_W    = 9;
	localparam int WEIGHT_FULL = 256;
	localparam int BLEND_SHIFT = 8;
	localparam int BLEND_W     = CHAN_W + WEIGHT_W;
	localparam int SQ_W        = 2 * SIDE_W;
	localparam int PROD_W      = 2 * SQ_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEXTURE_WIDTH  = 3'd0,
		REG_TEXTURE_HEIGHT = 3'd1,
		REG_REGION_X       = 3'd2,
		REG_REGION_Y       = 3'd3,
		REG_REGION_WIDTH   = 3'd4,
		REG_REGION_HEIGHT  = 3'd5,
		REG_CIRCULAR_MASK  = 3'd6,
		REG_BLEND_WEIGHT   = 3'd7
	} reg_idx_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic addr_calc;
		logic mem_read;
		logic blend_calc;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} dp_stat_t;

endpackage

[rtl/core/trmbw_if.sv]
// ---------------------------------------------------------------------------
// trmbw_if
// Handshake channels of the texture region blend writer.
// ---------------------------------------------------------------------------
interface trmbw_in_if;
	import trmbw_pkg::*;
	logic              valid;
	logic              ready;
	logic              op;
	logic [CHAN_W-1:0] in_red;
	logic [CHAN_W-1:0] in_green;
	logic [CHAN_W-1:0] in_blue;

	modport source (output valid, op, in_red, in_green, in_blue, input ready);
	modport sink (input valid, op, in_red, in_green, in_blue, output ready);
endinterface

interface trmbw_out_if;
	import trmbw_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] out_red;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_blue;
	logic [ADDR_W-1:0] pixel_index;
	logic              was_written;
	logic              last_pixel;
	logic              status;

	modport source (output valid, out_red, out_green, out_blue, pixel_index, was_written,
		last_pixel, status, input ready);
	modport sink (input valid, out_red, out_green, out_blue, pixel_index, was_written,
		last_pixel, status, output ready);
endinterface

interface trmbw_cfg_if;
	import trmbw_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/trmbw_ctrl.sv]
// ---------------------------------------------------------------------------
// trmbw_ctrl
// Sequencer: clears the store after reset, then steps one pixel word at a
// time through address, read, blend and write-back.
// ---------------------------------------------------------------------------
`include "texture_region_masked_blend_write_assert.svh"

module trmbw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  trmbw_pkg::dp_stat_t   stat,
	output trmbw_pkg::ctrl_cmd_t  cmd
);
	import trmbw_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_ADDR  = 6'b000100,
		S_READ  = 6'b001000,
		S_BLEND = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (stat.clear_last) state_d = S_IDLE;
			S_IDLE:  if (in_valid) state_d = S_ADDR;
			S_ADDR:  state_d = S_READ;
			S_READ:  state_d = S_BLEND;
			S_BLEND: state_d = S_FIN;
			S_FIN:   if (stat.out_free) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready       = (state_q == S_IDLE);
	assign cmd.clear      = (state_q == S_CLEAR);
	assign cmd.capture    = (state_q == S_IDLE) && in_valid;
	assign cmd.addr_calc  = (state_q == S_ADDR);
	assign cmd.mem_read   = (state_q == S_READ);
	assign cmd.blend_calc = (state_q == S_BLEND);
	assign cmd.finish     = (state_q == S_FIN) && stat.out_free;

	`TRMBW_ASSERT_NEXT(a_capture_starts, cmd.capture, state_q == S_ADDR)
	`TRMBW_ASSERT_NEXT(a_result_held, (state_q == S_FIN) && !stat.out_free, state_q == S_FIN)
	`TRMBW_ASSERT_NEXT(a_clear_ends, (state_q == S_CLEAR) && stat.clear_last, state_q == S_IDLE)

endmodule

[rtl/core/trmbw_dp.sv]
// ---------------------------------------------------------------------------
// trmbw_dp
// Datapath: configuration, region cursor, texture store, ellipse test,
// blend arithmetic and the output register.
// ---------------------------------------------------------------------------
module trmbw_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  trmbw_pkg::ctrl_cmd_t           cmd,
	output trmbw_pkg::dp_stat_t            stat,
	input  logic                           cfg_we,
	input  logic [trmbw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [trmbw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_op,
	input  logic [trmbw_pkg::CHAN_W-1:0]   in_red,
	input  logic [trmbw_pkg::CHAN_W-1:0]   in_green,
	input  logic [trmbw_pkg::CHAN_W-1:0]   in_blue,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [trmbw_pkg::CHAN_W-1:0]   out_red,
	output logic [trmbw_pkg::CHAN_W-1:0]   out_green,
	output logic [trmbw_pkg::CHAN_W-1:0]   out_blue,
	output logic [trmbw_pkg::ADDR_W-1:0]   pixel_index,
	output logic                           was_written,
	output logic                           last_pixel,
	output logic                           status
);
	import trmbw_pkg::*;

	logic [DIM_W-1:0]    tex_w_q, tex_h_q, reg_w_q, reg_h_q;
	logic [SIDE_W-1:0]   reg_x_q, reg_y_q;
	logic                mask_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [SIDE_W-1:0]   cur_col_q, cur_row_q;
	logic [ADDR_W-1:0]   clr_cnt_q;

	logic [PIX_W-1:0]    mem [DEPTH];

	logic                op_s1, err_s1, last_s1, ab_zero_s1;
	logic [PIX_W-1:0]    colour_s1;
	logic [SIDE_W-1:0]   col_s1, row_s1, dxa_s1, dya_s1, a_s1, b_s1;
	logic [ADDR_W-1:0]   addr_s2;
	logic [SQ_W-1:0]     dx2_s2, dy2_s2, a2_s2, b2_s2;
	logic [PIX_W-1:0]    old_s3;
	logic [PROD_W-1:0]   lhs_x_s3, lhs_y_s3, rhs_s3;
	logic                inside_s4;
	logic [NUM_CHAN-1:0][BLEND_W-1:0] mix_new_s4, mix_old_s4;

	logic                out_valid_q, written_q, last_q, status_q;
	logic [PIX_W-1:0]    out_px_q;
	logic [ADDR_W-1:0]   out_idx_q;

	logic [DIM_W:0]      x_end, y_end;
	logic [DIM_W-1:0]    col_inc, row_inc;
	logic                region_err, last_px;
	logic [SIDE_W-1:0]   half_a, half_b;
	logic [SIDE_W+DIM_W-1:0] addr_full;
	logic [PROD_W:0]     ell_sum;
	logic [WEIGHT_W-1:0] w_sat, w_inv;
	logic [PIX_W-1:0]    blend_px, result_px;
	logic                do_write;

	// Region checks and cursor arithmetic for the word being captured.
	always_comb begin
		x_end   = (DIM_W+1)'(reg_x_q) + (DIM_W+1)'(reg_w_q);
		y_end   = (DIM_W+1)'(reg_y_q) + (DIM_W+1)'(reg_h_q);
		col_inc = DIM_W'(cur_col_q) + DIM_W'(1);
		row_inc = DIM_W'(cur_row_q) + DIM_W'(1);
		region_err = (reg_w_q == '0) || (reg_h_q == '0) ||
			(tex_w_q == '0) || (tex_w_q > DIM_W'(MAX_SIDE)) ||
			(tex_h_q == '0) || (tex_h_q > DIM_W'(MAX_SIDE)) ||
			(x_end > (DIM_W+1)'(tex_w_q)) || (y_end > (DIM_W+1)'(tex_h_q)) ||
			(DIM_W'(cur_col_q) >= reg_w_q) || (DIM_W'(cur_row_q) >= reg_h_q);
		last_px = (col_inc == reg_w_q) && (row_inc == reg_h_q);
		half_a  = SIDE_W'(reg_w_q >> 1);
		half_b  = SIDE_W'(reg_h_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_w_q  <= DIM_W'(16);
			tex_h_q  <= DIM_W'(16);
			reg_x_q  <= '0;
			reg_y_q  <= '0;
			reg_w_q  <= DIM_W'(1);
			reg_h_q  <= DIM_W'(1);
			mask_q   <= 1'b0;
			weight_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_TEXTURE_WIDTH:  tex_w_q  <= cfg_data[DIM_W-1:0];
				REG_TEXTURE_HEIGHT: tex_h_q  <= cfg_data[DIM_W-1:0];
				REG_REGION_X:       reg_x_q  <= cfg_data[SIDE_W-1:0];
				REG_REGION_Y:       reg_y_q  <= cfg_data[SIDE_W-1:0];
				REG_REGION_WIDTH:   reg_w_q  <= cfg_data[DIM_W-1:0];
				REG_REGION_HEIGHT:  reg_h_q  <= cfg_data[DIM_W-1:0];
				REG_CIRCULAR_MASK:  mask_q   <= cfg_data[0];
				REG_BLEND_WEIGHT:   weight_q <= cfg_data[WEIGHT_W-1:0];
				default:            mask_q   <= mask_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else if (cfg_we || (cmd.capture && region_err)) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else if (cmd.capture) begin
			if (col_inc < reg_w_q) begin
				cur_col_q <= cur_col_q + SIDE_W'(1);
			end else begin
				cur_col_q <= '0;
				cur_row_q <= last_px ? '0 : cur_row_q + SIDE_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
		end
	end

	assign stat.clear_last = &clr_cnt_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1      <= in_op;
			colour_s1  <= {in_red, in_green, in_blue};
			err_s1     <= region_err;
			last_s1    <= last_px;
			col_s1     <= reg_x_q + cur_col_q;
			row_s1     <= reg_y_q + cur_row_q;
			dxa_s1     <= (cur_col_q > half_a) ? cur_col_q - half_a : half_a - cur_col_q;
			dya_s1     <= (cur_row_q > half_b) ? cur_row_q - half_b : half_b - cur_row_q;
			a_s1       <= half_a;
			b_s1       <= half_b;
			ab_zero_s1 <= (half_a == '0) || (half_b == '0);
		end
	end

	assign addr_full = (SIDE_W+DIM_W)'(row_s1) * (SIDE_W+DIM_W)'(tex_w_q) +
		(SIDE_W+DIM_W)'(col_s1);

	always_ff @(posedge clk) begin
		if (cmd.addr_calc) begin
			addr_s2 <= addr_full[ADDR_W-1:0];
			dx2_s2  <= SQ_W'(dxa_s1) * SQ_W'(dxa_s1);
			dy2_s2  <= SQ_W'(dya_s1) * SQ_W'(dya_s1);
			a2_s2   <= SQ_W'(a_s1) * SQ_W'(a_s1);
			b2_s2   <= SQ_W'(b_s1) * SQ_W'(b_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_read) begin
			lhs_x_s3 <= PROD_W'(dx2_s2) * PROD_W'(b2_s2);
			lhs_y_s3 <= PROD_W'(dy2_s2) * PROD_W'(a2_s2);
			rhs_s3   <= PROD_W'(a2_s2) * PROD_W'(b2_s2);
		end
	end

	// Texture store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			mem[clr_cnt_q] <= '0;
		end else if (cmd.finish && do_write) begin
			mem[addr_s2] <= blend_px;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_read) begin
			old_s3 <= mem[addr_s2];
		end
	end

	always_comb begin
		w_sat   = (weight_q > WEIGHT_W'(WEIGHT_FULL)) ? WEIGHT_W'(WEIGHT_FULL) : weight_q;
		w_inv   = WEIGHT_W'(WEIGHT_FULL) - w_sat;
		ell_sum = (PROD_W+1)'(lhs_x_s3) + (PROD_W+1)'(lhs_y_s3);
	end

	always_ff @(posedge clk) begin
		if (cmd.blend_calc) begin
			inside_s4 <= !ab_zero_s1 && (ell_sum <= (PROD_W+1)'(rhs_s3));
			for (int c = 0; c < NUM_CHAN; c++) begin
				mix_new_s4[c] <= BLEND_W'(colour_s1[c*CHAN_W +: CHAN_W]) * BLEND_W'(w_inv);
				mix_old_s4[c] <= BLEND_W'(old_s3[c*CHAN_W +: CHAN_W]) * BLEND_W'(w_sat);
			end
		end
	end

	always_comb begin
		logic [BLEND_W:0] mix_sum;
		blend_px = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			mix_sum = (BLEND_W+1)'(mix_new_s4[c]) + (BLEND_W+1)'(mix_old_s4[c]);
			blend_px[c*CHAN_W +: CHAN_W] = mix_sum[BLEND_SHIFT +: CHAN_W];
		end
		do_write  = !err_s1 && (op_t'(op_s1) == OP_WRITE) && (!mask_q || inside_s4);
		result_px = do_write ? blend_px : old_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_px_q  <= err_s1 ? '0 : result_px;
			out_idx_q <= err_s1 ? '0 : addr_s2;
			written_q <= do_write;
			last_q    <= !err_s1 && last_s1;
			status_q  <= err_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_red     = out_px_q[2*CHAN_W +: CHAN_W];
	assign out_green   = out_px_q[CHAN_W +: CHAN_W];
	assign out_blue    = out_px_q[0 +: CHAN_W];
	assign pixel_index = out_idx_q;
	assign was_written = written_q;
	assign last_pixel  = last_q;
	assign status      = status_q;

endmodule

[rtl/core/texture_region_masked_blend_write.sv]
// ---------------------------------------------------------------------------
// texture_region_masked_blend_write
// RGB texture store with region reads, blended writes and an elliptic mask.
// ---------------------------------------------------------------------------
// Usage. The cfg channel writes the eight registers by index; it is always
// ready and any write returns the region cursor to the first pixel. Each word
// on pix_in is the next region pixel in raster order, a read or a write; each
// accepted word yields exactly one word on pix_out with the colour stored
// afterwards, the texture address and the write, last-pixel and error flags.
// A bad region gives status 1 with all other fields zero and writes nothing.
// An accepted word passes through the address, read, blend and finish states
// before pix_out is valid, and no new word is taken until it is done: the
// address multiply, the registered read of the store, the blend multiplies
// and the write-back run one after another for each pixel. A finished word
// waits in the output register while the next pixel is taken; if the
// receiver still stalls when that pixel is done, the block holds it and
// stops accepting. After reset the store is swept to zero, one entry per
// cycle, and pix_in stays not ready during that sweep.
// ---------------------------------------------------------------------------
module texture_region_masked_blend_write (
	input  logic         clk,
	input  logic         arst_n,
	trmbw_cfg_if.sink    cfg,
	trmbw_in_if.sink     pix_in,
	trmbw_out_if.source  pix_out
);
	import trmbw_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	logic      in_ready;

	assign cfg.ready    = 1'b1;
	assign pix_in.ready = in_ready;

	trmbw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix_in.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	trmbw_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.in_op       (pix_in.op),
		.in_red      (pix_in.in_red),
		.in_green    (pix_in.in_green),
		.in_blue     (pix_in.in_blue),
		.out_ready   (pix_out.ready),
		.out_valid   (pix_out.valid),
		.out_red     (pix_out.out_red),
		.out_green   (pix_out.out_green),
		.out_blue    (pix_out.out_blue),
		.pixel_index (pix_out.pixel_index),
		.was_written (pix_out.was_written),
		.last_pixel  (pix_out.last_pixel),
		.status      (pix_out.status)
	);

endmodule
